@@ hw/rtl/pwm_channel_timer_allocator_assert.svh @@
// Assertion macros used by the checker file of the PWM channel timer allocator.
// Depends on nothing; a file that asserts includes it by its bare name.
`ifndef PWM_CHANNEL_TIMER_ALLOCATOR_ASSERT_SVH
`define PWM_CHANNEL_TIMER_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwm allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwm allocator check failed");

`endif

@@ hw/rtl/pcta_pkg.sv @@
// Package of the PWM channel timer allocator: sizes, status codes and table entry type.
// Depends on nothing; used by the top level and the checker.
package pcta_pkg;

  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned NUM_TIMERS   = 4;
  localparam int unsigned DUTY_BITS    = 10;
  localparam int unsigned PIN_BITS     = 6;

  localparam int unsigned FREQ_W   = 26;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TM_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // One scan step per timer frequency read, then one per channel entry read.
  localparam int unsigned SCAN_LEN = NUM_TIMERS + NUM_CHANNELS;
  localparam int unsigned STEP_W   = $clog2(SCAN_LEN);

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'((64'd1 << DUTY_BITS) - 64'd1);

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [PIN_BITS-1:0] pin;
    logic [TM_W-1:0]     timer;
  } chan_entry_t;

endpackage

@@ hw/rtl/pcta_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; instantiated by the allocator top level.
module pcta_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pwm_channel_timer_allocator.sv @@
// Top level of the PWM channel timer allocator: control, scan and commit logic.
// Depends on pcta_pkg and pcta_ram (channel table and timer frequency memories).
//
//   Channel   Direction  Handshake               Payload
//   request   in         in_valid_i / in_ready_o  pin_number_i, frequency_hz_i, duty_code_i
//   result    out        out_valid_o / out_ready_i status_o, channel_index_o, timer_index_o,
//                                                 timer_configured_o, duty_out_o
//
// The block reads the four timer frequencies and then the eight channel entries from two
// synchronous memories, one read per cycle, handles the last read data in S_LAST and
// commits the result in S_COMMIT, then returns to idle.
// Reset clears the channel in-use flags, the used-timer mask and all control state; the
// memories are not cleared, since the data of an entry is only used after it was written.
// A result waiting on out_ready_i does not block the next request transfer; only the
// commit of that next request waits until the output register is free.
module pwm_channel_timer_allocator
  import pcta_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIN_BITS-1:0] pin_number_i,
  input  logic [FREQ_W-1:0]   frequency_hz_i,
  input  logic [DUTY_W-1:0]   duty_code_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [CH_W-1:0]     channel_index_o,
  output logic [TM_W-1:0]     timer_index_o,
  output logic                timer_configured_o,
  output logic [DUTY_W-1:0]   duty_out_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_LAST   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Request held for the whole scan.
  logic [PIN_BITS-1:0] pin_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [DUTY_W-1:0]   duty_q;

  // Scan sequencing: step_q issues a read, rd_step_q tags the data that comes back.
  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] rd_step_q;
  logic              rd_valid_q;

  // Values gathered by the scan.
  logic [NUM_TIMERS-1:0] match_q;              // timer runs at the requested frequency
  logic [1:0]            users_q [NUM_TIMERS]; // in-use channels per timer, saturating at 2
  logic                  found_q;              // pin is held by an in-use channel
  logic [CH_W-1:0]       ch_q;
  logic [TM_W-1:0]       cur_q;                // timer bound to that channel
  logic                  tmf_q;                // a channel already runs a timer at freq_q
  logic [TM_W-1:0]       tm_q;

  // Architectural state kept in flops.
  logic [NUM_CHANNELS-1:0] in_use_q, in_use_d;
  logic [NUM_TIMERS-1:0]   mask_q, mask_d;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [CH_W-1:0]     res_ch_q, res_ch_d;
  logic [TM_W-1:0]     res_tm_q, res_tm_d;
  logic                res_cfg_q, res_cfg_d;
  logic [DUTY_W-1:0]   res_duty_q, res_duty_d;

  // Memory ports.
  logic              tf_we, tf_re;
  logic [TM_W-1:0]   tf_waddr, tf_raddr;
  logic [FREQ_W-1:0] tf_rdata;
  logic              ce_we, ce_re;
  logic [CH_W-1:0]   ce_waddr, ce_raddr;
  chan_entry_t       ce_wdata, ce_rdata;

  logic            in_fire, commit_fire, scan_timer_phase, rd_timer_phase;
  logic [CH_W-1:0] rd_ch;
  logic [TM_W-1:0] rd_tm;
  logic            free_ch_ok, free_tm_ok, shared;
  logic [CH_W-1:0] free_ch;
  logic [TM_W-1:0] free_tm, tm_sel;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign commit_fire = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  // Timer frequencies are read in the first steps of the scan, channel entries after.
  assign scan_timer_phase = (step_q < STEP_W'(NUM_TIMERS));
  assign rd_timer_phase   = (rd_step_q < STEP_W'(NUM_TIMERS));
  assign rd_tm            = rd_step_q[TM_W-1:0];
  assign rd_ch            = CH_W'(rd_step_q - STEP_W'(NUM_TIMERS));

  assign tf_re    = (state_q == S_SCAN) && scan_timer_phase;
  assign tf_raddr = step_q[TM_W-1:0];
  assign ce_re    = (state_q == S_SCAN) && !scan_timer_phase;
  assign ce_raddr = CH_W'(step_q - STEP_W'(NUM_TIMERS));

  // Writes only happen at commit and reads only during the next request's scan, so a
  // read never overlaps a write to the same entry.
  pcta_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (FREQ_W)
  ) u_timer_freq (
    .clk_i   (clk_i),
    .we_i    (tf_we),
    .waddr_i (tf_waddr),
    .wdata_i (freq_q),
    .re_i    (tf_re),
    .raddr_i (tf_raddr),
    .rdata_o (tf_rdata)
  );

  pcta_ram #(
    .DEPTH (NUM_CHANNELS),
    .WIDTH ($bits(chan_entry_t))
  ) u_chan_table (
    .clk_i   (clk_i),
    .we_i    (ce_we),
    .waddr_i (ce_waddr),
    .wdata_i (ce_wdata),
    .re_i    (ce_re),
    .raddr_i (ce_raddr),
    .rdata_o (ce_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step_q == STEP_W'(SCAN_LEN - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commit decision, worked out from the values the scan gathered.
  always_comb begin
    free_ch_ok = 1'b0;
    free_ch    = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_ch_ok = 1'b1;
        free_ch    = CH_W'(i);
      end
    end
    free_tm_ok = 1'b0;
    free_tm    = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!mask_q[i]) begin
        free_tm_ok = 1'b1;
        free_tm    = TM_W'(i);
      end
    end
  end

  // The requesting channel itself is one user of its timer, so two users means shared.
  assign shared = (users_q[cur_q] >= 2'd2);
  assign tm_sel = tmf_q ? tm_q : free_tm;

  always_comb begin
    in_use_d   = in_use_q;
    mask_d     = mask_q;
    tf_we      = 1'b0;
    tf_waddr   = tm_sel;
    ce_we      = 1'b0;
    ce_waddr   = ch_q;
    ce_wdata   = '{pin: pin_q, timer: tm_sel};
    status_d   = ST_NO_FREE;
    res_ch_d   = '0;
    res_tm_d   = '0;
    res_cfg_d  = 1'b0;
    res_duty_d = '0;
    if (freq_q == '0) begin
      if (!found_q) begin
        status_d = ST_NOT_FOUND;
      end else begin
        if (!shared) begin
          mask_d[cur_q] = 1'b0;
        end
        in_use_d[ch_q] = 1'b0;
        status_d       = ST_REMOVED;
        res_ch_d       = ch_q;
        res_tm_d       = cur_q;
      end
    end else if (found_q) begin
      if (match_q[cur_q]) begin
        // Same frequency: the binding stays, only the duty changes.
        status_d   = ST_UPDATED;
        res_ch_d   = ch_q;
        res_tm_d   = cur_q;
        res_duty_d = duty_q;
      end else if (tmf_q || free_tm_ok) begin
        if (!tmf_q) begin
          tf_we          = 1'b1;
          mask_d[tm_sel] = 1'b1;
          res_cfg_d      = 1'b1;
        end
        if (!shared) begin
          mask_d[cur_q] = 1'b0;
        end
        ce_we      = 1'b1;
        status_d   = ST_UPDATED;
        res_ch_d   = ch_q;
        res_tm_d   = tm_sel;
        res_duty_d = duty_q;
      end
    end else if (free_ch_ok && (tmf_q || free_tm_ok)) begin
      if (!tmf_q) begin
        tf_we     = 1'b1;
        res_cfg_d = 1'b1;
      end
      in_use_d[free_ch] = 1'b1;
      mask_d[tm_sel]    = 1'b1;
      ce_we             = 1'b1;
      ce_waddr          = free_ch;
      status_d          = ST_ADDED;
      res_ch_d          = free_ch;
      res_tm_d          = tm_sel;
      res_duty_d        = duty_q;
    end
    if (!commit_fire) begin
      tf_we    = 1'b0;
      ce_we    = 1'b0;
      in_use_d = in_use_q;
      mask_d   = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      rd_step_q   <= '0;
      rd_valid_q  <= 1'b0;
      in_use_q    <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      tmf_q       <= 1'b0;
      match_q     <= '0;
      ch_q        <= '0;
      cur_q       <= '0;
      tm_q        <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        users_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rd_valid_q <= (state_q == S_SCAN);
      rd_step_q  <= step_q;
      in_use_q   <= in_use_d;
      mask_q     <= mask_d;

      if (state_q == S_SCAN) begin
        step_q <= step_q + STEP_W'(1);
      end

      if (in_fire) begin
        step_q  <= '0;
        found_q <= 1'b0;
        tmf_q   <= 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          users_q[i] <= '0;
        end
      end

      // Scan data arrives in the cycle after its read was issued.
      if (rd_valid_q) begin
        if (rd_timer_phase) begin
          match_q[rd_tm] <= (tf_rdata == freq_q);
        end else if (in_use_q[rd_ch]) begin
          if (!found_q && (ce_rdata.pin == pin_q)) begin
            found_q <= 1'b1;
            ch_q    <= rd_ch;
            cur_q   <= ce_rdata.timer;
          end
          if (!tmf_q && match_q[ce_rdata.timer]) begin
            tmf_q <= 1'b1;
            tm_q  <= ce_rdata.timer;
          end
          if (users_q[ce_rdata.timer] < 2'd2) begin
            users_q[ce_rdata.timer] <= users_q[ce_rdata.timer] + 2'd1;
          end
        end
      end

      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pin_q  <= pin_number_i;
      freq_q <= frequency_hz_i;
      duty_q <= (duty_code_i > DUTY_MAX) ? DUTY_MAX : duty_code_i;
    end
    if (commit_fire) begin
      status_q   <= status_d;
      res_ch_q   <= res_ch_d;
      res_tm_q   <= res_tm_d;
      res_cfg_q  <= res_cfg_d;
      res_duty_q <= res_duty_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign channel_index_o    = res_ch_q;
  assign timer_index_o      = res_tm_q;
  assign timer_configured_o = res_cfg_q;
  assign duty_out_o         = res_duty_q;

endmodule

@@ hw/rtl/pcta_checker.sv @@
// Port-level checker of the PWM channel timer allocator, bound to the top level.
// Depends on pcta_pkg and the assertion macros in pwm_channel_timer_allocator_assert.svh.
`include "pwm_channel_timer_allocator_assert.svh"

module pcta_checker
  import pcta_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [CH_W-1:0]     channel_index_o,
  input logic [TM_W-1:0]     timer_index_o,
  input logic                timer_configured_o,
  input logic [DUTY_W-1:0]   duty_out_o
);

  logic out_failed, fail_fields_zero, out_removed, removed_quiet, out_stall;
  logic [STATUS_W+CH_W+TM_W+DUTY_W:0] out_payload;

  assign out_failed       = out_valid_o && (status_o == ST_NO_FREE || status_o == ST_NOT_FOUND);
  assign fail_fields_zero = (channel_index_o == '0) && (timer_index_o == '0) &&
                            !timer_configured_o && (duty_out_o == '0);
  assign out_removed      = out_valid_o && (status_o == ST_REMOVED);
  assign removed_quiet    = (duty_out_o == '0) && !timer_configured_o;
  assign out_stall        = out_valid_o && !out_ready_i;
  assign out_payload      = {status_o, channel_index_o, timer_index_o, timer_configured_o,
                             duty_out_o};

  // Only defined status codes leave the block.
  `PCTA_ASSERT_IMP(a_status_known, clk_i, rst_ni, out_valid_o, status_o <= ST_NOT_FOUND)

  // Failed requests report all other fields as zero.
  `PCTA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_failed, fail_fields_zero)

  // A removed channel is stopped low and never configures a timer.
  `PCTA_ASSERT_IMP(a_remove_low, clk_i, rst_ni, out_removed, removed_quiet)

  // One request at a time: after a request transfer the input side closes.
  `PCTA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A stalled result holds.
  `PCTA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_payload))

endmodule

bind pwm_channel_timer_allocator pcta_checker u_pcta_checker (.*);

@@ test/tb_top.sv @@
// Testbench for the PWM channel timer allocator: directed requests, then random ones.
// Depends on pcta_pkg and the pwm_channel_timer_allocator RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import pcta_pkg::*;

  // Clock, reset and the two handshake channels. Every input starts at a known value.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [PIN_BITS-1:0] pin_number_i = '0;
  logic [FREQ_W-1:0]   frequency_hz_i = '0;
  logic [DUTY_W-1:0]   duty_code_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [CH_W-1:0]     channel_index_o;
  logic [TM_W-1:0]     timer_index_o;
  logic                timer_configured_o;
  logic [DUTY_W-1:0]   duty_out_o;

  pwm_channel_timer_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pin_number_i       (pin_number_i),
    .frequency_hz_i     (frequency_hz_i),
    .duty_code_i        (duty_code_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .channel_index_o    (channel_index_o),
    .timer_index_o      (timer_index_o),
    .timer_configured_o (timer_configured_o),
    .duty_out_o         (duty_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One allocation outcome, as the block reports it on the result channel.
  typedef struct packed {
    status_e           status;
    logic [CH_W-1:0]   chan;
    logic [TM_W-1:0]   timer;
    logic              configured;
    logic [DUTY_W-1:0] duty;
  } alloc_result_t;

  // A directed request. When fixed_result is set, the outcome is typed in below
  // instead of being taken from the allocation predictor.
  typedef struct {
    logic [PIN_BITS-1:0] pin;
    logic [FREQ_W-1:0]   hz;
    logic [DUTY_W-1:0]   duty;
    bit                  fixed_result;
    alloc_result_t       outcome;
  } directed_req_t;

  localparam alloc_result_t NOT_FOUND_RES = '{ST_NOT_FOUND, '0, '0, 1'b0, '0};
  localparam alloc_result_t NO_FREE_RES   = '{ST_NO_FREE, '0, '0, 1'b0, '0};
  localparam alloc_result_t NONE_RES      = '{ST_ADDED, '0, '0, 1'b0, '0};
  localparam int unsigned   NUM_DIRECTED  = 23;
  localparam int unsigned   NUM_RANDOM    = 1330;
  localparam int unsigned   IDLE_PCT      = 21;

  // The directed walk fills the timers and channels to their limits, rebinds
  // channels between shared and private timers, and releases pins twice over.
  directed_req_t directed_reqs [NUM_DIRECTED] = '{
    // Release of a pin that was never allocated, right after reset.
    '{6'd5,  26'd0,        10'd0,    1'b1, NOT_FOUND_RES},
    // First allocations take channel 0/1 and configure timers 0/1.
    '{6'd0,  26'd1,        10'd0,    1'b1, '{ST_ADDED, 3'd0, 2'd0, 1'b1, 10'd0}},
    '{6'd63, 26'd40000000, 10'd1023, 1'b1, '{ST_ADDED, 3'd1, 2'd1, 1'b1, 10'd1023}},
    // Shares timer 0, then changes only the duty at the same frequency.
    '{6'd10, 26'd1,        10'd512,  1'b0, NONE_RES},
    '{6'd10, 26'd1,        10'd300,  1'b0, NONE_RES},
    // Pin 0 moves off a shared timer onto a freshly configured one.
    '{6'd0,  26'd1000,     10'd7,    1'b0, NONE_RES},
    '{6'd20, 26'd2000,     10'd1,    1'b0, NONE_RES},
    // All four timers busy at other frequencies.
    '{6'd21, 26'd3000,     10'd100,  1'b1, NO_FREE_RES},
    '{6'd20, 26'd3000,     10'd100,  1'b0, NONE_RES},
    // Rebind onto an existing timer, which frees the old private one.
    '{6'd20, 26'd40000000, 10'd2,    1'b0, NONE_RES},
    '{6'd21, 26'd3000,     10'd682,  1'b0, NONE_RES},
    '{6'd30, 26'd1,        10'd341,  1'b0, NONE_RES},
    '{6'd31, 26'd1,        10'd1022, 1'b0, NONE_RES},
    '{6'd32, 26'd1,        10'd1,    1'b0, NONE_RES},
    // Every channel busy.
    '{6'd33, 26'd1,        10'd5,    1'b1, NO_FREE_RES},
    // Releases: shared timer kept, then the last user frees it.
    '{6'd63, 26'd0,        10'd1023, 1'b0, NONE_RES},
    '{6'd20, 26'd0,        10'd9,    1'b0, NONE_RES},
    '{6'd20, 26'd0,        10'd9,    1'b1, NOT_FOUND_RES},
    '{6'd33, 26'd5,        10'd5,    1'b0, NONE_RES},
    '{6'd21, 26'd1000,     10'd3,    1'b0, NONE_RES},
    '{6'd0,  26'd0,        10'd0,    1'b0, NONE_RES},
    '{6'd21, 26'd0,        10'd0,    1'b0, NONE_RES},
    '{6'd45, 26'd33554431, 10'd682,  1'b0, NONE_RES}
  };

  // Small pools make pins collide and frequencies repeat, so that the random part
  // keeps hitting updates, shared timers and full tables.
  localparam logic [PIN_BITS-1:0] PIN_POOL [12] = '{
    6'd0, 6'd63, 6'd1, 6'd62, 6'd7, 6'd56, 6'd21, 6'd42, 6'd13, 6'd50, 6'd35, 6'd28
  };
  localparam logic [FREQ_W-1:0] HZ_POOL [6] = '{
    26'd1, 26'd50, 26'd1000, 26'd20000, 26'd33554432, 26'd40000000
  };

  // Shadow of the allocator's channel table and timers.
  logic                ch_busy  [NUM_CHANNELS];
  logic [PIN_BITS-1:0] ch_pin   [NUM_CHANNELS];
  logic [TM_W-1:0]     ch_timer [NUM_CHANNELS];
  logic [DUTY_W-1:0]   ch_duty  [NUM_CHANNELS];
  logic [NUM_TIMERS-1:0] timer_busy;
  logic [FREQ_W-1:0]   timer_hz [NUM_TIMERS];

  alloc_result_t pending_results [$];
  int unsigned   error_count = 0;
  int unsigned   requests_sent = 0;
  int unsigned   status_seen [5] = '{0, 0, 0, 0, 0};
  bit            steady = 1'b0;

  function automatic int first_free_timer();
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (!timer_busy[t]) return t;
    end
    return -1;
  endfunction

  // True when some other in-use channel is bound to the same timer as channel ch.
  function automatic bit timer_has_other_user(int ch);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i != ch && ch_busy[i] && ch_timer[i] == ch_timer[ch]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow tables and returns the outcome it must produce.
  function automatic alloc_result_t predict_allocation(logic [PIN_BITS-1:0] pin,
                                                       logic [FREQ_W-1:0] hz,
                                                       logic [DUTY_W-1:0] duty_in);
    int ch;
    int tm;
    int old_tm;
    logic [DUTY_W-1:0] duty;
    alloc_result_t res;
    ch = -1;
    tm = -1;
    res = NONE_RES;
    duty = (duty_in > DUTY_MAX) ? DUTY_MAX : duty_in;
    // The lowest in-use channel holding the pin owns it.
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (ch_busy[i] && ch_pin[i] == pin) ch = i;
    end

    if (hz == '0) begin
      if (ch < 0) return NOT_FOUND_RES;
      old_tm = ch_timer[ch];
      if (!timer_has_other_user(ch)) timer_busy[old_tm] = 1'b0;
      ch_busy[ch] = 1'b0;
      res.status = ST_REMOVED;
      res.chan   = CH_W'(ch);
      res.timer  = TM_W'(old_tm);
      return res;
    end

    // A timer already running at this frequency, found through the lowest channel on it.
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (ch_busy[i] && timer_hz[ch_timer[i]] == hz) tm = ch_timer[i];
    end

    if (ch >= 0) begin
      if (timer_hz[ch_timer[ch]] != hz) begin
        if (tm < 0) begin
          tm = first_free_timer();
          if (tm < 0) return NO_FREE_RES;
          timer_hz[tm] = hz;
          timer_busy[tm] = 1'b1;
          res.configured = 1'b1;
        end
        if (!timer_has_other_user(ch)) timer_busy[ch_timer[ch]] = 1'b0;
        ch_timer[ch] = TM_W'(tm);
      end
      ch_duty[ch] = duty;
      res.status = ST_UPDATED;
      res.chan   = CH_W'(ch);
      res.timer  = ch_timer[ch];
      res.duty   = duty;
      return res;
    end

    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!ch_busy[i]) ch = i;
    end
    if (ch < 0) return NO_FREE_RES;
    if (tm < 0) begin
      tm = first_free_timer();
      if (tm < 0) return NO_FREE_RES;
      timer_hz[tm] = hz;
      res.configured = 1'b1;
    end
    ch_busy[ch]  = 1'b1;
    ch_pin[ch]   = pin;
    ch_timer[ch] = TM_W'(tm);
    ch_duty[ch]  = duty;
    timer_busy[tm] = 1'b1;
    res.status = ST_ADDED;
    res.chan   = CH_W'(ch);
    res.timer  = TM_W'(tm);
    res.duty   = duty;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0d ns: %s", $time, msg);
  endtask

  // Presents one request, holds it until its transfer, and records the outcome
  // that must come back. Called and returning at a falling edge; valid is only
  // lowered when an idle gap is taken, so it never drops between back-to-back requests.
  task automatic send_request(input logic [PIN_BITS-1:0] pin, input logic [FREQ_W-1:0] hz,
                              input logic [DUTY_W-1:0] duty, input bit fixed_result,
                              input alloc_result_t fixed_outcome);
    alloc_result_t predicted;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    pin_number_i   <= pin;
    frequency_hz_i <= hz;
    duty_code_i    <= duty;
    do @(posedge clk_i); while (!in_ready_o);
    // The predictor runs for typed rows too, so the shadow tables stay in step.
    predicted = predict_allocation(pin, hz, duty);
    pending_results.push_back(fixed_result ? fixed_outcome : predicted);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Result side: ready drops at random except during the steady stretch.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every result transfer is checked against the oldest outstanding outcome.
  always @(posedge clk_i) begin
    alloc_result_t seen;
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.status     = status_e'(status_o);
      seen.chan       = channel_index_o;
      seen.timer      = timer_index_o;
      seen.configured = timer_configured_o;
      seen.duty       = duty_out_o;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing outstanding: status %0d ch %0d",
                             status_o, channel_index_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o < 5) status_seen[status_o]++;
        if (seen.status !== want.status || seen.chan !== want.chan ||
            seen.timer !== want.timer || seen.configured !== want.configured ||
            seen.duty !== want.duty) begin
          flag_error($sformatf({"result mismatch: expected st %0d ch %0d tm %0d cfg %0d ",
                                "duty %0d, got st %0d ch %0d tm %0d cfg %0d duty %0d"},
                               want.status, want.chan, want.timer, want.configured,
                               want.duty, status_o, channel_index_o, timer_index_o,
                               timer_configured_o, duty_out_o));
        end
      end
    end
  end

  // Main sequence: reset, directed walk, random requests, drain.
  initial begin
    logic [PIN_BITS-1:0] pin;
    logic [FREQ_W-1:0]   hz;
    logic [DUTY_W-1:0]   duty;
    int unsigned         pick;
    int unsigned         drain_cycles;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_busy[i]  = 1'b0;
      ch_pin[i]   = '0;
      ch_timer[i] = '0;
      ch_duty[i]  = '0;
    end
    for (int t = 0; t < NUM_TIMERS; t++) timer_hz[t] = '0;
    timer_busy = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i].pin, directed_reqs[i].hz, directed_reqs[i].duty,
                   directed_reqs[i].fixed_result, directed_reqs[i].outcome);
    end

    // Mostly pooled pins and frequencies with about one release in four, plus
    // some fully random pins and frequencies as noise.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady = (n >= 500 && n < 700);
      pick = $urandom_range(99);
      pin = (pick < 80) ? PIN_POOL[$urandom_range(11)] : PIN_BITS'($urandom_range(63));
      pick = $urandom_range(99);
      if (pick < 25) hz = '0;
      else if (pick < 85) hz = HZ_POOL[$urandom_range(5)];
      else hz = FREQ_W'($urandom_range(40000000, 1));
      pick = $urandom_range(99);
      if (pick < 5) duty = '0;
      else if (pick < 10) duty = DUTY_MAX;
      else duty = DUTY_W'($urandom_range(1023));
      send_request(pin, hz, duty, 1'b0, NONE_RES);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    // Leave room for a stray extra result after the last one expected.
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests: %0d added, %0d updated, %0d removed,", requests_sent,
             status_seen[ST_ADDED], status_seen[ST_UPDATED], status_seen[ST_REMOVED]);
    $display("%0d refused for lack of a channel or timer, %0d unknown pin releases; %0d errors.",
             status_seen[ST_NO_FREE], status_seen[ST_NOT_FOUND], error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Timeout: simulation did not complete");
    $display("Verification failed");
    $finish;
  end

endmodule
